// File: rtl/core/i2cseq_pkg.sv
// Shared types, codes and helpers for the I2C EEPROM transfer sequencer.
// No dependencies; every module of the block imports this package.
`default_nettype none

package i2cseq_pkg;

   // Memory geometry
   localparam int MEMORY_BYTES = 131072;
   localparam int PAGE_BYTES   = 256;
   localparam int HALF_BYTES   = MEMORY_BYTES / 2;
   localparam int PAGE_LOG     = $clog2(PAGE_BYTES);

   // Field widths
   localparam int ADDR_W  = 18;
   localparam int CLEN_W  = 17;
   localparam int WADDR_W = 16;
   localparam int QCNT_W  = 4;
   localparam int TICK_W  = 8;
   localparam int CSR_W   = 8;

   // Configuration register reset values and the query-count saturation value
   localparam logic [TICK_W-1:0] RETRY_DELAY_RESET = 8'd5;
   localparam logic [QCNT_W-1:0] MAX_QUERIES_RESET = 4'd8;
   localparam logic [QCNT_W-1:0] QUERY_SAT         = 4'hf;

   // Request function codes
   localparam logic [1:0] FUNC_READ     = 2'd0;
   localparam logic [1:0] FUNC_WRITE    = 2'd1;
   localparam logic [1:0] FUNC_COMPLETE = 2'd2;
   localparam logic [1:0] FUNC_TICK     = 2'd3;

   // Bus completion results
   localparam logic [1:0] BUS_OK     = 2'd0;
   localparam logic [1:0] BUS_NO_ACK = 2'd1;

   // Result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_CMD    = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   // Status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_RANGE    = 2'd1;
   localparam logic [1:0] ST_BUSY     = 2'd2;
   localparam logic [1:0] ST_BUS_ERR  = 2'd3;

   // Transfer phases
   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_READ  = 2'd1;
   localparam logic [1:0] PH_WRITE = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_CHIP_ENABLE = 2'd0;
   localparam logic [1:0] CSR_DEVICE_OPEN = 2'd1;
   localparam logic [1:0] CSR_RETRY_DELAY = 2'd2;
   localparam logic [1:0] CSR_MAX_QUERIES = 2'd3;

   // Device byte base
   localparam logic [7:0] DEV_BASE = 8'hA0;

   // Planned chunk for the current position of a transfer
   typedef struct packed {
      logic                 range_bad;
      logic                 bank;
      logic [WADDR_W-1:0]   word_address;
      logic [CLEN_W-1:0]    chunk_length;
   } chunk_type;

   // One result item
   typedef struct packed {
      logic [1:0]           kind;
      logic [1:0]           status;
      logic [7:0]           device_byte;
      logic [WADDR_W-1:0]   word_address;
      logic [CLEN_W-1:0]    chunk_length;
      logic                 is_read;
      logic [ADDR_W-1:0]    buffer_offset;
   } rsp_type;

   // Device byte: base | e2<<4 | e1<<3 | bank<<1
   function automatic logic [7:0] dev_byte(input logic [1:0] pins, input logic bank);
      dev_byte = DEV_BASE | {3'b000, pins[1], pins[0], 1'b0, bank, 1'b0};
   endfunction

endpackage

`default_nettype wire

// File: rtl/core/i2c_eeprom_transfer_sequencer_core.sv
// Top level of the I2C EEPROM transfer sequencer: request register, config
// registers, and assertions. Depends on i2cseq_pkg, i2cseq_ctrl, i2cseq_rsp_buf.
`default_nettype none

// Sequencer for a two-bank 128 KiB I2C EEPROM. Each request (start read,
// start write, bus completion, timer tick) yields zero or one response: an
// immediate status, a bus command for the next chunk, or a transfer-finished
// report. One request is taken every clock cycle while req_stall is low; a
// request's response passes through the request register, then the response
// register. The rate is set by the transfer-state update, computed from the
// request register and stored with the response. A skid stage behind the
// response register holds one response under rsp_stall; once full, req_stall rises.
// Configuration writes are always ready and must be made while idle.
module i2c_eeprom_transfer_sequencer_core (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [17:0] req_start_address,
   input  wire logic [17:0] req_byte_count,
   input  wire logic [1:0]  req_bus_result,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_kind,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_device_byte,
   output logic [15:0]      rsp_word_address,
   output logic [16:0]      rsp_chunk_length,
   output logic             rsp_is_read,
   output logic [17:0]      rsp_buffer_offset,
   // configuration write port
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [7:0]  csr_data
);
   import i2cseq_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_func_ff;
   logic [ADDR_W-1:0] in_addr_ff;
   logic [ADDR_W-1:0] in_count_ff;
   logic [1:0]        in_bus_ff;

   logic [1:0]        pins_ff;
   logic              open_ff;
   logic [TICK_W-1:0] delay_ff;
   logic [QCNT_W-1:0] maxq_ff;

   logic              req_accept;
   logic              skid_full;
   logic              fire;
   logic              rsp_push;
   rsp_type           rsp_new;
   rsp_type           rsp_out;
   logic [1:0]        phase;
   logic              retry_pending;

   // request register: refills whenever the control stage can take its item
   assign fire        = in_valid_ff && !skid_full;
   assign req_stall   = in_valid_ff && skid_full;
   assign req_accept  = req_valid && !req_stall;
   assign in_valid_in = req_accept || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_func_ff  <= req_func;
         in_addr_ff  <= req_start_address;
         in_count_ff <= req_byte_count;
         in_bus_ff   <= req_bus_result;
      end
   end

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pins_ff  <= '0;
         open_ff  <= 1'b0;
         delay_ff <= RETRY_DELAY_RESET;
         maxq_ff  <= MAX_QUERIES_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CHIP_ENABLE: pins_ff  <= csr_data[1:0];
            CSR_DEVICE_OPEN: open_ff  <= csr_data[0];
            CSR_RETRY_DELAY: delay_ff <= csr_data[TICK_W-1:0];
            CSR_MAX_QUERIES: maxq_ff  <= csr_data[QCNT_W-1:0];
            default: ;
         endcase
      end
   end

   i2cseq_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .fire              (fire),
      .func              (in_func_ff),
      .start_address     (in_addr_ff),
      .byte_count        (in_count_ff),
      .bus_result        (in_bus_ff),
      .chip_enable_pins  (pins_ff),
      .device_open       (open_ff),
      .retry_delay_ticks (delay_ff),
      .max_queries       (maxq_ff),
      .rsp_push          (rsp_push),
      .rsp_data          (rsp_new),
      .phase             (phase),
      .retry_pending     (retry_pending)
   );

   i2cseq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_new),
      .skid_full (skid_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_out)
   );

   assign rsp_kind          = rsp_out.kind;
   assign rsp_status        = rsp_out.status;
   assign rsp_device_byte   = rsp_out.device_byte;
   assign rsp_word_address  = rsp_out.word_address;
   assign rsp_chunk_length  = rsp_out.chunk_length;
   assign rsp_is_read       = rsp_out.is_read;
   assign rsp_buffer_offset = rsp_out.buffer_offset;

`ifndef SYNTH
   // a held skid entry always sits behind a full response register
   a_skid_behind_main: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> rsp_valid)
      else $error("skid entry without a response in the output register");

   // a bus command leaves the transfer in progress
   a_cmd_keeps_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && (rsp_new.kind == KIND_CMD)) |=> (phase != PH_IDLE))
      else $error("bus command issued but sequencer went idle");

   // a retry is only ever pending inside a transfer
   a_retry_in_transfer: assert property (@(posedge clock) disable iff (reset)
      retry_pending |-> (phase != PH_IDLE))
      else $error("retry pending while idle");

   // nothing is pushed while the skid stage is occupied
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      skid_full |-> !rsp_push)
      else $error("response pushed into a full buffer");
`endif

endmodule

`default_nettype wire

// File: rtl/core/i2cseq_chunk.sv
// Chunk planner: range check, bank split and page split of one transfer step.
// Purely combinational; depends on i2cseq_pkg.
`default_nettype none

module i2cseq_chunk (
   input  wire logic [17:0]           addr,
   input  wire logic [17:0]           len,
   input  wire logic                  is_write,
   output i2cseq_pkg::chunk_type      plan
);
   import i2cseq_pkg::*;

   localparam logic [ADDR_W:0]   MEM_LIMIT = (ADDR_W+1)'(MEMORY_BYTES);
   localparam logic [ADDR_W-1:0] HALF      = ADDR_W'(HALF_BYTES);
   localparam logic [ADDR_W-1:0] PAGE      = ADDR_W'(PAGE_BYTES);

   logic [ADDR_W:0]   end_sum;
   logic              bank;
   logic [ADDR_W-1:0] local_addr;
   logic [ADDR_W-1:0] bank_room;
   logic [ADDR_W-1:0] page_room;
   logic [ADDR_W-1:0] clen;

   always_comb begin
      // range check on start and end of the remaining transfer
      end_sum = {1'b0, addr} + {1'b0, len};
      plan.range_bad = ({1'b0, addr} > MEM_LIMIT) || (end_sum > MEM_LIMIT);

      // bank split
      bank       = (addr >= HALF);
      local_addr = bank ? (addr - HALF) : addr;
      bank_room  = HALF - addr;
      clen       = len;
      if (!bank && (bank_room < len)) begin
         clen = bank_room;
      end

      // writes never cross a page
      page_room = PAGE - ADDR_W'(local_addr[PAGE_LOG-1:0]);
      if (is_write && (page_room < clen)) begin
         clen = page_room;
      end

      plan.bank         = bank;
      plan.word_address = local_addr[WADDR_W-1:0];
      plan.chunk_length = clen[CLEN_W-1:0];
   end

endmodule

`default_nettype wire

// File: rtl/core/i2cseq_rsp_buf.sv
// Result register with skid stage for the response channel.
// Depends on i2cseq_pkg for the result struct.
`default_nettype none

module i2cseq_rsp_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire i2cseq_pkg::rsp_type push_data,
   output logic                     skid_full,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output i2cseq_pkg::rsp_type      rsp_data
);
   import i2cseq_pkg::*;

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    main_take;

   // main register refills when empty or drained; skid catches one behind it
   always_comb begin
      main_take     = !main_valid_ff || !rsp_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_take) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign skid_full = skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

endmodule

`default_nettype wire

// File: rtl/core/i2cseq_ctrl.sv
// Transfer state and per-request decision logic of the sequencer.
// Depends on i2cseq_pkg and instantiates i2cseq_chunk.
`default_nettype none

module i2cseq_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire logic [1:0]          func,
   input  wire logic [17:0]         start_address,
   input  wire logic [17:0]         byte_count,
   input  wire logic [1:0]          bus_result,
   input  wire logic [1:0]          chip_enable_pins,
   input  wire logic                device_open,
   input  wire logic [7:0]          retry_delay_ticks,
   input  wire logic [3:0]          max_queries,
   output logic                     rsp_push,
   output i2cseq_pkg::rsp_type      rsp_data,
   output logic [1:0]               phase,
   output logic                     retry_pending
);
   import i2cseq_pkg::*;

   logic [1:0]         phase_ff, phase_in;
   logic [ADDR_W-1:0]  cur_addr_ff, cur_addr_in;
   logic [ADDR_W-1:0]  remain_ff, remain_in;
   logic [ADDR_W-1:0]  done_off_ff, done_off_in;
   logic [CLEN_W-1:0]  last_len_ff, last_len_in;
   logic [QCNT_W-1:0]  query_cnt_ff, query_cnt_in;
   logic [TICK_W-1:0]  countdown_ff, countdown_in;
   logic               pending_ff, pending_in;

   logic [ADDR_W-1:0]  comp_addr, comp_remain, comp_off;
   logic [ADDR_W-1:0]  chunk_addr, chunk_len, chunk_off;
   logic               chunk_write;
   chunk_type          plan;
   logic               do_issue;
   logic               push;
   rsp_type            res;
   logic [QCNT_W-1:0]  qnext;

   // position after a successful completion
   always_comb begin
      comp_addr   = cur_addr_ff + ADDR_W'(last_len_ff);
      comp_remain = remain_ff - ADDR_W'(last_len_ff);
      comp_off    = done_off_ff + ADDR_W'(last_len_ff);
   end

   // chunk source: the new request, the advanced position, or the current one
   always_comb begin
      case (func)
         FUNC_READ, FUNC_WRITE: begin
            chunk_addr  = start_address;
            chunk_len   = byte_count;
            chunk_off   = '0;
            chunk_write = (func == FUNC_WRITE);
         end
         FUNC_COMPLETE: begin
            chunk_addr  = comp_addr;
            chunk_len   = comp_remain;
            chunk_off   = comp_off;
            chunk_write = (phase_ff == PH_WRITE);
         end
         default: begin
            chunk_addr  = cur_addr_ff;
            chunk_len   = remain_ff;
            chunk_off   = done_off_ff;
            chunk_write = (phase_ff == PH_WRITE);
         end
      endcase
   end

   i2cseq_chunk u_chunk (
      .addr     (chunk_addr),
      .len      (chunk_len),
      .is_write (chunk_write),
      .plan     (plan)
   );

   // event handling
   always_comb begin
      phase_in     = phase_ff;
      cur_addr_in  = cur_addr_ff;
      remain_in    = remain_ff;
      done_off_in  = done_off_ff;
      last_len_in  = last_len_ff;
      query_cnt_in = query_cnt_ff;
      countdown_in = countdown_ff;
      pending_in   = pending_ff;
      do_issue     = 1'b0;
      push         = 1'b0;
      res          = '0;
      qnext        = query_cnt_ff;

      case (func)
         FUNC_READ, FUNC_WRITE: begin
            push = 1'b1;
            if (plan.range_bad) begin
               res.kind   = KIND_STATUS;
               res.status = ST_RANGE;
            end else if (phase_ff != PH_IDLE) begin
               res.kind   = KIND_STATUS;
               res.status = ST_BUSY;
            end else begin
               cur_addr_in  = start_address;
               remain_in    = byte_count;
               done_off_in  = '0;
               last_len_in  = '0;
               query_cnt_in = '0;
               pending_in   = 1'b0;
               countdown_in = '0;
               phase_in     = (func == FUNC_READ) ? PH_READ : PH_WRITE;
               do_issue     = 1'b1;
            end
         end
         FUNC_COMPLETE: begin
            if (phase_ff != PH_IDLE) begin
               pending_in   = 1'b0;
               countdown_in = '0;
               if (bus_result == BUS_NO_ACK) begin
                  if (query_cnt_ff != QUERY_SAT) begin
                     qnext = query_cnt_ff + 1'b1;
                  end
                  query_cnt_in = qnext;
                  if (qnext < max_queries) begin
                     pending_in   = 1'b1;
                     countdown_in = retry_delay_ticks;
                  end else begin
                     phase_in   = PH_IDLE;
                     push       = 1'b1;
                     res.kind   = KIND_FINISH;
                     res.status = ST_BUS_ERR;
                  end
               end else if (bus_result != BUS_OK) begin
                  phase_in   = PH_IDLE;
                  push       = 1'b1;
                  res.kind   = KIND_FINISH;
                  res.status = ST_BUS_ERR;
               end else begin
                  cur_addr_in = comp_addr;
                  done_off_in = comp_off;
                  remain_in   = comp_remain;
                  if (comp_remain == '0) begin
                     phase_in   = PH_IDLE;
                     push       = 1'b1;
                     res.kind   = KIND_FINISH;
                     res.status = ST_OK;
                  end else begin
                     do_issue = 1'b1;
                  end
               end
            end
         end
         default: begin
            // timer tick: count down a pending retry
            if (pending_ff) begin
               if (countdown_ff > 8'd1) begin
                  countdown_in = countdown_ff - 1'b1;
               end else begin
                  countdown_in = '0;
                  pending_in   = 1'b0;
                  if (device_open) begin
                     if (phase_ff == PH_IDLE) begin
                        push       = 1'b1;
                        res.kind   = KIND_FINISH;
                        res.status = ST_BUS_ERR;
                     end else begin
                        do_issue = 1'b1;
                     end
                  end
               end
            end
         end
      endcase

      // bus command for the chunk at the new position, or a range finish
      if (do_issue) begin
         push = 1'b1;
         if (plan.range_bad) begin
            phase_in   = PH_IDLE;
            res.kind   = KIND_FINISH;
            res.status = ST_RANGE;
         end else begin
            last_len_in       = plan.chunk_length;
            res.kind          = KIND_CMD;
            res.status        = ST_OK;
            res.device_byte   = dev_byte(chip_enable_pins, plan.bank);
            res.word_address  = plan.word_address;
            res.chunk_length  = plan.chunk_length;
            res.is_read       = !chunk_write;
            res.buffer_offset = chunk_off;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cur_addr_ff  <= '0;
         remain_ff    <= '0;
         done_off_ff  <= '0;
         last_len_ff  <= '0;
         query_cnt_ff <= '0;
         countdown_ff <= '0;
         pending_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff     <= phase_in;
         cur_addr_ff  <= cur_addr_in;
         remain_ff    <= remain_in;
         done_off_ff  <= done_off_in;
         last_len_ff  <= last_len_in;
         query_cnt_ff <= query_cnt_in;
         countdown_ff <= countdown_in;
         pending_ff   <= pending_in;
      end
   end

   assign rsp_push      = fire && push;
   assign rsp_data      = res;
   assign phase         = phase_ff;
   assign retry_pending = pending_ff;

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for i2c_eeprom_transfer_sequencer_core: directed and random
// request traffic with a built-in transfer predictor. Depends on i2cseq_pkg and the core.

module tb;
   import i2cseq_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = '0;
   logic [17:0] req_start_address = '0;
   logic [17:0] req_byte_count = '0;
   logic [1:0]  req_bus_result = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_kind;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_device_byte;
   logic [15:0] rsp_word_address;
   logic [16:0] rsp_chunk_length;
   logic        rsp_is_read;
   logic [17:0] rsp_buffer_offset;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   i2c_eeprom_transfer_sequencer_core u_top (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted register copy
   logic [1:0]  cfg_pins = '0;
   logic        cfg_open = 1'b0;
   logic [7:0]  cfg_delay = RETRY_DELAY_RESET;
   logic [3:0]  cfg_max_nack = MAX_QUERIES_RESET;

   // Predicted transfer state
   logic [1:0]  xfer_phase = PH_IDLE;
   logic [17:0] xfer_addr = '0;
   logic [17:0] xfer_left = '0;
   logic [17:0] xfer_offset = '0;
   logic [16:0] xfer_chunk = '0;
   logic [3:0]  nack_count = '0;
   logic [7:0]  retry_wait = '0;
   logic        retry_armed = 1'b0;

   rsp_type     rsps_due[$];
   int          error_count = 0;
   int          burst_left = 10;
   int          long_hold_cycles = 0;
   int          stall_mode = 0;
   int          stall_mode_left = 0;

   task automatic report_mismatch(input string msg);
      $display("%0t ERROR %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [17:0] got,
                              input logic [17:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   function automatic bit out_of_range(input logic [17:0] a, input logic [17:0] n);
      int unsigned ua, un;
      ua = a;
      un = n;
      return (ua > MEMORY_BYTES) || (ua + un > MEMORY_BYTES);
   endfunction

   function automatic void end_transfer(output rsp_type r, input logic [1:0] st);
      r = '0;
      xfer_phase = PH_IDLE;
      r.kind = KIND_FINISH;
      r.status = st;
   endfunction

   // Bus command for the chunk at the current position: bank split, page split on writes
   function automatic void plan_chunk(output rsp_type r);
      int unsigned a, n, offs, clen, room;
      logic bank;
      r = '0;
      a = xfer_addr;
      n = xfer_left;
      if (out_of_range(xfer_addr, xfer_left)) begin
         end_transfer(r, ST_RANGE);
         return;
      end
      bank = (a >= HALF_BYTES);
      offs = bank ? a - HALF_BYTES : a;
      clen = bank ? n : HALF_BYTES - a;
      if (!bank && n < clen) clen = n;
      if (xfer_phase == PH_WRITE) begin
         room = PAGE_BYTES - (offs % PAGE_BYTES);
         if (room < clen) clen = room;
      end
      xfer_chunk = clen[16:0];
      r.kind = KIND_CMD;
      r.status = ST_OK;
      r.device_byte = {3'b101, cfg_pins[1], cfg_pins[0], 1'b0, bank, 1'b0};
      r.word_address = offs[15:0];
      r.chunk_length = xfer_chunk;
      r.is_read = (xfer_phase == PH_READ);
      r.buffer_offset = xfer_offset;
   endfunction

   // Advance the predicted sequencer by one request; returns 1 when a response is due
   function automatic bit sequence_request(input logic [1:0] f, input logic [17:0] a,
                                           input logic [17:0] n, input logic [1:0] res,
                                           output rsp_type r);
      r = '0;
      case (f)
         FUNC_READ, FUNC_WRITE: begin
            if (out_of_range(a, n)) begin
               r.kind = KIND_STATUS;
               r.status = ST_RANGE;
               return 1'b1;
            end
            if (xfer_phase != PH_IDLE) begin
               r.kind = KIND_STATUS;
               r.status = ST_BUSY;
               return 1'b1;
            end
            xfer_addr = a;
            xfer_left = n;
            xfer_offset = '0;
            xfer_chunk = '0;
            nack_count = '0;
            retry_armed = 1'b0;
            retry_wait = '0;
            xfer_phase = (f == FUNC_READ) ? PH_READ : PH_WRITE;
            plan_chunk(r);
            return 1'b1;
         end
         FUNC_COMPLETE: begin
            if (xfer_phase == PH_IDLE) return 1'b0;
            retry_armed = 1'b0;
            retry_wait = '0;
            if (res == BUS_NO_ACK) begin
               if (nack_count != QUERY_SAT) nack_count++;
               if (nack_count < cfg_max_nack) begin
                  retry_armed = 1'b1;
                  retry_wait = cfg_delay;
                  return 1'b0;
               end
               end_transfer(r, ST_BUS_ERR);
               return 1'b1;
            end
            if (res != BUS_OK) begin
               end_transfer(r, ST_BUS_ERR);
               return 1'b1;
            end
            xfer_addr = xfer_addr + xfer_chunk;
            xfer_offset = xfer_offset + xfer_chunk;
            xfer_left = xfer_left - xfer_chunk;
            if (xfer_left == 0) begin
               end_transfer(r, ST_OK);
               return 1'b1;
            end
            plan_chunk(r);
            return 1'b1;
         end
         default: begin
            // timer tick: only matters with a retry armed
            if (!retry_armed) return 1'b0;
            if (retry_wait > 1) begin
               retry_wait--;
               return 1'b0;
            end
            retry_wait = '0;
            retry_armed = 1'b0;
            if (!cfg_open) return 1'b0;
            if (xfer_phase == PH_IDLE) begin
               end_transfer(r, ST_BUS_ERR);
               return 1'b1;
            end
            plan_chunk(r);
            return 1'b1;
         end
      endcase
   endfunction

   // Present one request and hold it until taken; called at a rising edge
   task automatic send_request(input logic [1:0] f, input logic [17:0] a,
                               input logic [17:0] n, input logic [1:0] res);
      rsp_type r;
      req_valid <= 1'b1;
      req_func <= f;
      req_start_address <= a;
      req_byte_count <= n;
      req_bus_result <= res;
      do @(posedge clock); while (req_stall);
      if (sequence_request(f, a, n, res, r)) rsps_due.push_back(r);
   endtask

   // Send in bursts with random gaps between them
   task automatic offer_request(input logic [1:0] f, input logic [17:0] a,
                                input logic [17:0] n, input logic [1:0] res);
      send_request(f, a, n, res);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end else begin
         burst_left--;
      end
   endtask

   // Stop sending and wait until every predicted response has arrived
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (rsps_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [7:0] pins, input logic [7:0] open,
                                 input logic [7:0] delay, input logic [7:0] maxq);
      logic [7:0] vals[4];
      logic [1:0] regs[4];
      vals = '{pins, open, delay, maxq};
      regs = '{CSR_CHIP_ENABLE, CSR_DEVICE_OPEN, CSR_RETRY_DELAY, CSR_MAX_QUERIES};
      drain_responses();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= regs[i];
         csr_data <= vals[i];
         do @(posedge clock); while (!csr_ready);
         case (regs[i])
            CSR_CHIP_ENABLE: cfg_pins = vals[i][1:0];
            CSR_DEVICE_OPEN: cfg_open = vals[i][0];
            CSR_RETRY_DELAY: cfg_delay = vals[i];
            default:         cfg_max_nack = vals[i][3:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   // Legal transfer, biased toward the bank boundary and the top of memory
   function automatic void pick_transfer(input logic [1:0] f, output logic [17:0] a,
                                         output logic [17:0] n);
      int unsigned sel, base, len;
      sel = $urandom_range(0, 99);
      if (sel < 20) base = HALF_BYTES - $urandom_range(0, 300);
      else if (sel < 25) base = MEMORY_BYTES - $urandom_range(0, 40);
      else base = $urandom_range(0, MEMORY_BYTES);
      sel = $urandom_range(0, 99);
      if (sel < 70) len = $urandom_range(0, 600);
      else if (sel < 95 || f == FUNC_WRITE) len = $urandom_range(0, 3000);
      else len = $urandom_range(0, MEMORY_BYTES);
      if (len > MEMORY_BYTES - base) len = MEMORY_BYTES - base;
      a = base[17:0];
      n = len[17:0];
   endfunction

   // Receiver stall pattern, with an occasional long hold-off
   always @(posedge clock) begin
      if (stall_mode_left == 0) begin
         stall_mode = $urandom_range(0, 3);
         stall_mode_left = $urandom_range(20, 200);
      end else begin
         stall_mode_left--;
      end
      if (long_hold_cycles != 0) begin
         long_hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         case (stall_mode)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            2:       rsp_stall <= (stall_mode_left % 3 == 0);
            default: rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
      end
   end

   // Response checker
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rsps_due.size() == 0) begin
            report_mismatch("response with no request outstanding");
         end else begin
            want = rsps_due.pop_front();
            check_field("kind", rsp_kind, want.kind);
            check_field("status", rsp_status, want.status);
            check_field("device_byte", rsp_device_byte, want.device_byte);
            check_field("word_address", rsp_word_address, want.word_address);
            check_field("chunk_length", rsp_chunk_length, want.chunk_length);
            check_field("is_read", rsp_is_read, want.is_read);
            check_field("buffer_offset", rsp_buffer_offset, want.buffer_offset);
         end
      end
   end

   // Range rejects, address at the very top with zero length, idle completion and tick
   task automatic test_range_checks();
      apply_settings(8'd1, 8'd1, 8'd5, 8'd8);
      offer_request(FUNC_READ, MEMORY_BYTES + 1, 18'd0, BUS_OK);
      offer_request(FUNC_WRITE, 18'h3ffff, 18'h3ffff, BUS_OK);
      offer_request(FUNC_READ, MEMORY_BYTES, 18'd0, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_TICK, 18'd0, 18'd0, BUS_OK);
   endtask

   // Write across a page and the bank boundary; range is checked before busy
   task automatic test_bank_and_page_split();
      offer_request(FUNC_WRITE, HALF_BYTES - 16, 18'd48, BUS_OK);
      offer_request(FUNC_READ, MEMORY_BYTES, 18'd1, BUS_OK);
      offer_request(FUNC_READ, 18'd5, 18'd10, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_OK);
   endtask

   // Retry after delay, query limit, completion cancelling a retry, bus error
   task automatic test_retry_and_errors();
      apply_settings(8'd3, 8'd1, 8'd2, 8'd2);
      offer_request(FUNC_READ, 18'd100, 18'd5, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_NO_ACK);
      offer_request(FUNC_TICK, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_TICK, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_NO_ACK);
      offer_request(FUNC_WRITE, 18'd7, 18'd3, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_NO_ACK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_WRITE, 18'd9, 18'd1, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, 2'd3);
   endtask

   // Query limit of zero; a due retry dropped while closed leaves the block busy
   task automatic test_closed_and_zero_limit();
      apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
      offer_request(FUNC_READ, 18'd1, 18'd1, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_NO_ACK);
      apply_settings(8'd1, 8'd0, 8'd0, 8'd15);
      offer_request(FUNC_READ, 18'd2, 18'd2, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, BUS_NO_ACK);
      offer_request(FUNC_TICK, 18'd0, 18'd0, BUS_OK);
      offer_request(FUNC_COMPLETE, 18'd0, 18'd0, 2'd2);
   endtask

   // Long receiver hold-off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      apply_settings(8'd2, 8'd1, 8'd1, 8'd3);
      long_hold_cycles = 150;
      repeat (40)
         send_request($urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ,
                      $urandom_range(MEMORY_BYTES + 1, 18'h3ffff),
                      $urandom_range(0, 18'h3ffff), BUS_OK);
      drain_responses();
   endtask

   // Mostly well-formed transfers with random content, plus noise
   task automatic run_random_phase(input int target);
      int          done_items;
      int unsigned pick, nack_pct;
      logic [1:0]  f, res;
      logic [17:0] a, n;
      done_items = 0;
      nack_pct = (cfg_delay > 20) ? 3 : 12;
      while (done_items < target) begin
         pick = $urandom_range(0, 99);
         a = $urandom_range(0, 18'h3ffff);
         n = $urandom_range(0, 18'h3ffff);
         res = $urandom_range(0, 3);
         if (xfer_phase == PH_IDLE) begin
            f = pick[0] ? FUNC_WRITE : FUNC_READ;
            if (pick < 85) pick_transfer(f, a, n);
            else if (pick >= 93) f = pick[0] ? FUNC_TICK : FUNC_COMPLETE;
         end else if (retry_armed) begin
            if (pick < 85) f = FUNC_TICK;
            else if (pick < 93) f = FUNC_COMPLETE;
            else begin
               f = pick[0] ? FUNC_WRITE : FUNC_READ;
               if (pick[1]) pick_transfer(f, a, n);
            end
         end else begin
            if (pick < 80) begin
               f = FUNC_COMPLETE;
               res = ($urandom_range(0, 99) < nack_pct) ? BUS_NO_ACK : BUS_OK;
            end else if (pick < 85) begin
               f = FUNC_COMPLETE;
            end else if (pick < 92) begin
               f = FUNC_TICK;
            end else begin
               f = pick[0] ? FUNC_WRITE : FUNC_READ;
               if (pick[1]) pick_transfer(f, a, n);
            end
         end
         // ignored requests do not count
         if (!((f == FUNC_COMPLETE && xfer_phase == PH_IDLE) ||
               (f == FUNC_TICK && !retry_armed)))
            done_items++;
         offer_request(f, a, n, res);
      end
   endtask

   task automatic test_random_traffic();
      apply_settings(8'd0, 8'd1, 8'd1, 8'd1);
      run_random_phase(270);
      apply_settings(8'd3, 8'd1, 8'd255, 8'd15);
      run_random_phase(270);
      apply_settings(8'hfe, 8'd1, 8'd0, 8'd0);
      run_random_phase(270);
      apply_settings(8'd1, 8'd0, 8'd4, 8'd6);
      run_random_phase(270);
      apply_settings($urandom_range(0, 255), 8'd1, $urandom_range(1, 12),
                     $urandom_range(1, 15));
      run_random_phase(270);
      apply_settings(8'd2, 8'hff, 8'd2, 8'd3);
      run_random_phase(270);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_range_checks();
      test_bank_and_page_split();
      test_retry_and_errors();
      test_closed_and_zero_limit();
      test_backpressure();
      test_random_traffic();
      drain_responses();
      if (error_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

// File: files.f
rtl/core/i2cseq_pkg.sv
rtl/core/i2cseq_chunk.sv
rtl/core/i2cseq_rsp_buf.sv
rtl/core/i2cseq_ctrl.sv
rtl/core/i2c_eeprom_transfer_sequencer_core.sv
dv/tb.sv
